>>> hdl/spedu_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spedu_pkg
// Shared types and constants of the stereo panned echo delay unit.
// -----------------------------------------------------------------------------
package spedu_pkg;

   // configuration register file
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int DELAY_BITS    = 12;
   localparam int GAIN_BITS     = 16;
   localparam int PAN_BITS      = 16;
   localparam int WEIGHT_BITS   = PAN_BITS + 1;      // pan weight, 0 .. 65536
   localparam int GW_BITS       = 32;                // gain * weight, < 2^32

   localparam logic [CSR_ADDR_BITS-1:0] REG_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_DELAY  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_GAIN   = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PAN    = 2'd3;

   localparam logic [GAIN_BITS-1:0]   GAIN_RESET  = 16'd16384;   // unity, Q2.14
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_HALF = 17'd32768;   // 0.5 in Q1.16

   // Rounding: add half of 2^30, then arithmetic shift by 30
   localparam int ROUND_SHIFT = 30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic capture;    // take input item, access history, form gain*weight
      logic multiply;   // delayed sample times gain*weight
      logic finish;     // round, add, saturate into output register
   } cmd_type;

endpackage

>>> hdl/spedu_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spedu_ctrl
// Sequencer: one item at a time through capture, multiply and finish, plus
// the valid flag of the output register.
// -----------------------------------------------------------------------------
module spedu_ctrl
   import spedu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
         end
         ST_SUM: begin
            cmd.finish = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

>>> hdl/spedu_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spedu_datapath
// Config registers, history memories with write pointer, gain/pan multiply,
// rounding, mixing and saturation.
// -----------------------------------------------------------------------------
module spedu_datapath
   import spedu_pkg::*;
#(
   parameter int DELAY_DEPTH = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  cmd_type                       cmd,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out
);

   localparam int PTR_BITS = $clog2(DELAY_DEPTH);
   localparam int CMP_BITS = (PTR_BITS > DELAY_BITS ? PTR_BITS : DELAY_BITS) + 1;
   localparam int PROD_BITS = SAMPLE_BITS + GW_BITS + 1;
   localparam int ECHO_BITS = PROD_BITS - ROUND_SHIFT;
   localparam int SUM_BITS  = SAMPLE_BITS + 4;

   // ---------------- configuration registers
   logic                        enable_ff;
   logic [DELAY_BITS-1:0]       delay_ff;
   logic [GAIN_BITS-1:0]        gain_ff;
   logic signed [PAN_BITS-1:0]  pan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         delay_ff  <= '0;
         gain_ff   <= GAIN_RESET;
         pan_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ENABLE: enable_ff <= csr_wdata[0];
            REG_DELAY:  delay_ff  <= csr_wdata[DELAY_BITS-1:0];
            REG_GAIN:   gain_ff   <= csr_wdata[GAIN_BITS-1:0];
            REG_PAN:    pan_ff    <= csr_wdata[PAN_BITS-1:0];
         endcase
      end
   end

   // ---------------- pointers
   logic [PTR_BITS-1:0] wp_ff, wp_in;
   logic                wrapped_ff, wrapped_in;
   logic [CMP_BITS-1:0] delay_wide, delay_clamp;
   logic [PTR_BITS-1:0] dist_ptr, rp;
   logic [PTR_BITS:0]   rp_wrap;
   logic                hist_valid;
   logic                at_end;

   assign delay_wide  = CMP_BITS'(delay_ff);
   assign delay_clamp = (delay_wide >= CMP_BITS'(DELAY_DEPTH)) ? CMP_BITS'(DELAY_DEPTH - 1)
                                                               : delay_wide;
   assign dist_ptr = delay_clamp[PTR_BITS-1:0];
   assign rp_wrap  = {1'b0, wp_ff} + (PTR_BITS+1)'(DELAY_DEPTH) - {1'b0, dist_ptr};
   assign rp       = (wp_ff >= dist_ptr) ? (wp_ff - dist_ptr) : rp_wrap[PTR_BITS-1:0];

   // entries 0 .. wp-1 written so far, or all of them once the pointer wrapped
   assign hist_valid = wrapped_ff || (rp < wp_ff);
   assign at_end     = (wp_ff == PTR_BITS'(DELAY_DEPTH - 1));

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (cmd.capture && enable_ff) begin
         wp_in = at_end ? '0 : wp_ff + 1'b1;
         if (at_end) wrapped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // ---------------- history memories (read before write)
   logic signed [SAMPLE_BITS-1:0] left_mem  [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_mem [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] hist_l_ff, hist_r_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hist_l_ff <= left_mem[rp];
         if (enable_ff) left_mem[wp_ff] <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hist_r_ff <= right_mem[rp];
         if (enable_ff) right_mem[wp_ff] <= right_in;
      end
   end

   // ---------------- capture stage: inputs and gain * pan weight
   logic [WEIGHT_BITS-1:0]        wl, wr;
   logic [GW_BITS:0]              gwl_full, gwr_full;
   logic [GW_BITS-1:0]            gw_l_ff, gw_r_ff;
   logic signed [SAMPLE_BITS-1:0] in_l_ff, in_r_ff;
   logic                          use_hist_ff;

   assign wl = WEIGHT_HALF - {pan_ff[PAN_BITS-1], pan_ff};
   assign wr = WEIGHT_HALF + {pan_ff[PAN_BITS-1], pan_ff};
   assign gwl_full = gain_ff * wl;
   assign gwr_full = gain_ff * wr;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_l_ff     <= left_in;
         in_r_ff     <= right_in;
         gw_l_ff     <= gwl_full[GW_BITS-1:0];
         gw_r_ff     <= gwr_full[GW_BITS-1:0];
         use_hist_ff <= enable_ff && hist_valid;
      end
   end

   // ---------------- multiply stage
   logic signed [SAMPLE_BITS-1:0] dl, dr;
   logic signed [PROD_BITS-1:0]   prod_l, prod_r, prod_l_ff, prod_r_ff;

   assign dl = use_hist_ff ? hist_l_ff : '0;
   assign dr = use_hist_ff ? hist_r_ff : '0;
   assign prod_l = dl * $signed({1'b0, gw_l_ff});
   assign prod_r = dr * $signed({1'b0, gw_r_ff});

   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         prod_l_ff <= prod_l;
         prod_r_ff <= prod_r;
      end
   end

   // ---------------- round, mix, saturate
   logic signed [PROD_BITS-1:0]   rnd_l, rnd_r;
   logic signed [ECHO_BITS-1:0]   echo_l, echo_r;
   logic signed [SUM_BITS-1:0]    sum_l, sum_r;
   logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   assign rnd_l = prod_l_ff + (PROD_BITS'(1) <<< (ROUND_SHIFT - 1));
   assign rnd_r = prod_r_ff + (PROD_BITS'(1) <<< (ROUND_SHIFT - 1));

   // floor shift after the half offset: nearest, ties toward plus infinity
   assign echo_l = $signed(rnd_l[PROD_BITS-1:ROUND_SHIFT]);
   assign echo_r = $signed(rnd_r[PROD_BITS-1:ROUND_SHIFT]);
   assign sum_l  = SUM_BITS'(in_l_ff) + SUM_BITS'(echo_l);
   assign sum_r  = SUM_BITS'(in_r_ff) + SUM_BITS'(echo_r);

   function automatic logic [SAMPLE_BITS-1:0] saturate(input logic [SUM_BITS-1:0] v);
      logic [SUM_BITS-SAMPLE_BITS:0] top;
      top = v[SUM_BITS-1:SAMPLE_BITS-1];
      if ((top == '0) || (top == '1)) begin
         saturate = v[SAMPLE_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         saturate = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         saturate = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   assign sat_l = saturate(sum_l);
   assign sat_r = saturate(sum_r);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_l_ff <= sat_l;
         out_r_ff <= sat_r;
      end
   end

   assign left_out  = out_l_ff;
   assign right_out = out_r_ff;

endmodule

>>> hdl/stereo_panned_echo_delay_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stereo_panned_echo_delay_unit
// Stereo echo: each frame is mixed with a panned, gain-scaled copy read from
// a pair of ring buffers DELAY_DEPTH frames deep.
// -----------------------------------------------------------------------------
// Timing: the history is read at accept, then the multiply, then round/mix/
//    saturate into the output register, which raises rsp_tvalid.
// Flow: the three-step sequencer carries one item at a time; the next item
//    is taken while a result waits, and it holds in the last step until the
//    output register is free.
// Reset: synchronous, active high; clears control, pointer and config regs.
//    History reads as zero until written (pointer wrap tracking), so no
//    clearing pass is run and the unit is ready right after reset.
// -----------------------------------------------------------------------------
module stereo_panned_echo_delay_unit
   import spedu_pkg::*;
#(
   parameter int DELAY_DEPTH = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,  // left_in, right_in
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,  // left_out, right_out
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int PAD_BITS  = DATA_BITS - 2*SAMPLE_BITS;

   cmd_type                       cmd;
   logic signed [SAMPLE_BITS-1:0] left_in, right_in, left_out, right_out;

   // unpack the frame: left in the low bits, right above it
   assign left_in  = req_tdata[SAMPLE_BITS-1:0];
   assign right_in = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   // sequencer: hands one item through capture, multiply and finish, and owns
   // the valid bit of the output register
   spedu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: config regs, ring buffers, multiply and saturate
   spedu_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .left_in   (left_in),
      .right_in  (right_in),
      .left_out  (left_out),
      .right_out (right_out)
   );

   // pack the result, zero fill up to a whole byte
   generate
      if (PAD_BITS > 0) begin : g_pad
         assign rsp_tdata = {{PAD_BITS{1'b0}}, right_out, left_out};
      end else begin : g_nopad
         assign rsp_tdata = {right_out, left_out};
      end
   endgenerate

endmodule
